>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define RQPS_ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rqps assertion failed");

// consequent holds in the same cycle as the antecedent
`define RQPS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rqps assertion failed");

// consequent holds in the cycle after the antecedent
`define RQPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rqps assertion failed");

`endif

>>> rtl/rqps_pkg.sv
package rqps_pkg;

   localparam int DEPTH_DEFAULT      = 128;
   localparam int KEY_BITS_DEFAULT   = 16;
   localparam int INDEX_BITS_DEFAULT = $clog2(DEPTH_DEFAULT);

   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 2;

   // command codes
   localparam logic [CMD_BITS-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_FIND    = 2'd2;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd3;

endpackage

>>> rtl/rqps_req_if.sv
interface rqps_req_if #(
   parameter int KEY_BITS = rqps_pkg::KEY_BITS_DEFAULT
) ();
   logic                          valid;
   logic                          ready;
   logic [rqps_pkg::CMD_BITS-1:0] command;
   logic [KEY_BITS-1:0]           ticket_number;

   modport source (output valid, output command, output ticket_number, input ready);
   modport sink   (input valid, input command, input ticket_number, output ready);
endinterface

>>> rtl/rqps_rsp_if.sv
interface rqps_rsp_if #(
   parameter int KEY_BITS   = rqps_pkg::KEY_BITS_DEFAULT,
   parameter int INDEX_BITS = rqps_pkg::INDEX_BITS_DEFAULT
) ();
   logic                             valid;
   logic                             ready;
   logic [rqps_pkg::STATUS_BITS-1:0] status;
   logic [INDEX_BITS-1:0]            ahead_count;
   logic [KEY_BITS-1:0]              removed_number;
   logic [INDEX_BITS-1:0]            queue_length;

   modport source (output valid, output status, output ahead_count,
                   output removed_number, output queue_length, input ready);
   modport sink   (input valid, input status, input ahead_count,
                   input removed_number, input queue_length, output ready);
endinterface

>>> rtl/ring_queue_with_position_search_unit.sv
// channel   direction  transfer contents
// req_ch    in         command, ticket_number
// rsp_ch    out        status, ahead_count, removed_number, queue_length
//
// one item is worked at a time; enqueue, unused command and empty dequeue/find
// load the result register in the accept cycle
// dequeue passes through ST_READ for the registered read of the head slot
// find walks from the head and stops at a match k entries behind it or after the
// last held entry; the single slot memory read port walks one entry a cycle
// reset is synchronous: pointers, length and valid flags clear, slot contents do not
// a new item is taken only when idle and the result register is empty or
// its transfer completes in the same cycle; a stalled result holds in place
`include "assert_macros.svh"

module ring_queue_with_position_search_unit #(
   parameter int DEPTH    = rqps_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = rqps_pkg::KEY_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   rqps_req_if.sink   req_ch,
   rqps_rsp_if.source rsp_ch
);
   localparam int INDEX_BITS = $clog2(DEPTH);
   localparam logic [INDEX_BITS-1:0] LAST_INDEX = INDEX_BITS'(DEPTH - 1);
   localparam logic [INDEX_BITS:0]   DEPTH_WIDE = (INDEX_BITS + 1)'(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEARCH
   } state_type;

   // ring pointer step, wraps at the last slot
   function automatic logic [INDEX_BITS-1:0] next_index(input logic [INDEX_BITS-1:0] p);
      return (p == LAST_INDEX) ? '0 : p + 1'b1;
   endfunction

   state_type state_ff, state_in;

   logic [INDEX_BITS-1:0] head_ff, head_in;
   logic [INDEX_BITS-1:0] tail_ff, tail_in;
   logic [INDEX_BITS-1:0] count_ff, count_in;

   // search context
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [INDEX_BITS-1:0] scan_ptr_ff, scan_ptr_in;
   logic [INDEX_BITS-1:0] scan_cnt_ff, scan_cnt_in;

   // result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [rqps_pkg::STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [INDEX_BITS-1:0]            rsp_ahead_ff, rsp_ahead_in;
   logic [KEY_BITS-1:0]              rsp_removed_ff, rsp_removed_in;
   logic [INDEX_BITS-1:0]            rsp_length_ff, rsp_length_in;

   // slot memory port signals
   logic                  mem_wr_en;
   logic                  mem_rd_en;
   logic [INDEX_BITS-1:0] mem_rd_addr;
   logic [KEY_BITS-1:0]   mem_rd_data;

   logic req_ready;
   logic req_fire;
   logic rsp_fire;

   // tail position implied by head and length, checked against the tail pointer
   logic [INDEX_BITS:0]   tail_sum;
   logic [INDEX_BITS-1:0] tail_expect;

   rqps_slot_mem #(
      .DEPTH (DEPTH),
      .WIDTH (KEY_BITS)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_ch.ticket_number),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // accept only when idle and the result register is free by the next edge
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire  = req_ch.valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ch.ready;

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      key_in         = key_ff;
      scan_ptr_in    = scan_ptr_ff;
      scan_cnt_in    = scan_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_fire;
      rsp_status_in  = rsp_status_ff;
      rsp_ahead_in   = rsp_ahead_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_length_in  = rsp_length_ff;
      mem_wr_en      = 1'b0;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // default result: ok, nothing ahead, nothing removed, length unchanged
               rsp_status_in  = rqps_pkg::STATUS_OK;
               rsp_ahead_in   = '0;
               rsp_removed_in = '0;
               rsp_length_in  = count_ff;
               unique case (req_ch.command)
                  rqps_pkg::CMD_ENQUEUE: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == LAST_INDEX) begin
                        rsp_status_in = rqps_pkg::STATUS_FULL;
                     end else begin
                        mem_wr_en     = 1'b1;
                        tail_in       = next_index(tail_ff);
                        count_in      = count_ff + 1'b1;
                        rsp_length_in = count_ff + 1'b1;
                     end
                  end
                  rqps_pkg::CMD_DEQUEUE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = rqps_pkg::STATUS_EMPTY;
                     end else begin
                        // head slot comes back next cycle
                        mem_rd_en = 1'b1;
                        state_in  = ST_READ;
                     end
                  end
                  rqps_pkg::CMD_FIND: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = rqps_pkg::STATUS_EMPTY;
                     end else begin
                        mem_rd_en   = 1'b1;
                        key_in      = req_ch.ticket_number;
                        scan_ptr_in = next_index(head_ff);
                        scan_cnt_in = '0;
                        state_in    = ST_SEARCH;
                     end
                  end
                  default: begin
                     // unused command: state untouched, only the length reported
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in   = 1'b1;
            rsp_removed_in = mem_rd_data;
            head_in        = next_index(head_ff);
            count_in       = count_ff - 1'b1;
            rsp_length_in  = count_ff - 1'b1;
            state_in       = ST_IDLE;
         end
         ST_SEARCH: begin
            // read data belongs to the entry scan_cnt_ff places behind the head
            if (mem_rd_data == key_ff) begin
               rsp_valid_in = 1'b1;
               rsp_ahead_in = scan_cnt_ff;
               state_in     = ST_IDLE;
            end else if (scan_cnt_ff == count_ff - 1'b1) begin
               // last held entry checked, stop before the tail
               rsp_valid_in  = 1'b1;
               rsp_status_in = rqps_pkg::STATUS_NOT_FOUND;
               state_in      = ST_IDLE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = scan_ptr_ff;
               scan_ptr_in = next_index(scan_ptr_ff);
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff         <= key_in;
      scan_ptr_ff    <= scan_ptr_in;
      scan_cnt_ff    <= scan_cnt_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_ahead_ff   <= rsp_ahead_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_length_ff  <= rsp_length_in;
   end

   assign req_ch.ready          = req_ready;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.ahead_count    = rsp_ahead_ff;
   assign rsp_ch.removed_number = rsp_removed_ff;
   assign rsp_ch.queue_length   = rsp_length_ff;

   assign tail_sum    = {1'b0, head_ff} + {1'b0, count_ff};
   assign tail_expect = (tail_sum >= DEPTH_WIDE) ? INDEX_BITS'(tail_sum - DEPTH_WIDE)
                                                 : tail_sum[INDEX_BITS-1:0];

   // pointers and length must describe the same ring
   `RQPS_ASSERT_HOLDS(a_ring_consistent, clock, reset, tail_expect == tail_ff)

   // a search only runs over a non-empty queue and never past its length
   `RQPS_ASSERT_IMPLIES(a_search_in_range, clock, reset, state_ff == ST_SEARCH, (count_ff != '0) && (scan_cnt_ff < count_ff))

   // an enqueue into a full ring leaves it full and reports it
   `RQPS_ASSERT_NEXT(a_full_refused, clock, reset, req_fire && (req_ch.command == rqps_pkg::CMD_ENQUEUE) && (count_ff == LAST_INDEX), $stable(count_ff) && rsp_valid_ff && (rsp_status_ff == rqps_pkg::STATUS_FULL))

   // a memory read result is always consumed before a new item is taken
   `RQPS_ASSERT_IMPLIES(a_busy_blocks_req, clock, reset, (state_ff == ST_READ) || (state_ff == ST_SEARCH), !req_ready && !rsp_valid_ff)
endmodule

>>> rtl/rqps_slot_mem.sv
module rqps_slot_mem #(
   parameter int DEPTH = rqps_pkg::DEPTH_DEFAULT,
   parameter int WIDTH = rqps_pkg::KEY_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds its value when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> tb/tb.sv
module tb;

   localparam int DEPTH        = rqps_pkg::DEPTH_DEFAULT;
   localparam int KEY_BITS     = rqps_pkg::KEY_BITS_DEFAULT;
   localparam int INDEX_BITS   = rqps_pkg::INDEX_BITS_DEFAULT;
   localparam int TICKET_ITEMS = 1550;
   localparam int IDLE_PCT     = 19;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int MAX_REPORTS  = 10;
   localparam int ROW_COUNT    = 22;

   // command value with no operation behind it
   localparam logic [rqps_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   // traffic mix of the random part
   localparam int MIX_FILL  = 0;
   localparam int MIX_DRAIN = 1;
   localparam int MIX_EVEN  = 2;

   typedef struct packed {
      logic [rqps_pkg::STATUS_BITS-1:0] status;
      logic [INDEX_BITS-1:0]            ahead;
      logic [KEY_BITS-1:0]              removed;
      logic [INDEX_BITS-1:0]            length;
   } queue_result_type;

   typedef struct {
      logic [rqps_pkg::CMD_BITS-1:0] command;
      logic [KEY_BITS-1:0]           ticket;
      int                            reps;
      bit                            literal;
      queue_result_type              result;
   } stim_row_type;

   localparam queue_result_type NO_LITERAL = '0;

   // directed stimulus; rows without a literal are checked against the predictor
   // repeated rows step the ticket by one per transfer
   stim_row_type ticket_rows [ROW_COUNT] = '{
      // empty queue right after reset
      '{rqps_pkg::CMD_DEQUEUE, 16'h0000, 1, 1'b1,
        '{rqps_pkg::STATUS_EMPTY, 7'd0, 16'h0000, 7'd0}},
      '{rqps_pkg::CMD_FIND, 16'hFFFF, 1, 1'b1,
        '{rqps_pkg::STATUS_EMPTY, 7'd0, 16'h0000, 7'd0}},
      '{CMD_UNUSED, 16'hFFFF, 1, 1'b1,
        '{rqps_pkg::STATUS_OK, 7'd0, 16'h0000, 7'd0}},
      // extremes of the ticket, with a duplicate
      '{rqps_pkg::CMD_ENQUEUE, 16'hFFFF, 1, 1'b1,
        '{rqps_pkg::STATUS_OK, 7'd0, 16'h0000, 7'd1}},
      '{rqps_pkg::CMD_ENQUEUE, 16'h0000, 1, 1'b1,
        '{rqps_pkg::STATUS_OK, 7'd0, 16'h0000, 7'd2}},
      '{rqps_pkg::CMD_ENQUEUE, 16'hFFFF, 1, 1'b1,
        '{rqps_pkg::STATUS_OK, 7'd0, 16'h0000, 7'd3}},
      // duplicate: match nearest the head wins
      '{rqps_pkg::CMD_FIND, 16'hFFFF, 1, 1'b1,
        '{rqps_pkg::STATUS_OK, 7'd0, 16'h0000, 7'd3}},
      '{rqps_pkg::CMD_FIND, 16'h0000, 1, 1'b1,
        '{rqps_pkg::STATUS_OK, 7'd1, 16'h0000, 7'd3}},
      '{rqps_pkg::CMD_FIND, 16'h1234, 1, 1'b1,
        '{rqps_pkg::STATUS_NOT_FOUND, 7'd0, 16'h0000, 7'd3}},
      '{CMD_UNUSED, 16'h0000, 1, 1'b1,
        '{rqps_pkg::STATUS_OK, 7'd0, 16'h0000, 7'd3}},
      '{rqps_pkg::CMD_DEQUEUE, 16'h0000, 1, 1'b1,
        '{rqps_pkg::STATUS_OK, 7'd0, 16'hFFFF, 7'd2}},
      // fill to the brim, the ring wraps behind the head
      '{rqps_pkg::CMD_ENQUEUE, 16'h8000, 125, 1'b0, NO_LITERAL},
      '{rqps_pkg::CMD_ENQUEUE, 16'h5555, 1, 1'b1,
        '{rqps_pkg::STATUS_FULL, 7'd0, 16'h0000, 7'd127}},
      '{CMD_UNUSED, 16'h5555, 1, 1'b1,
        '{rqps_pkg::STATUS_OK, 7'd0, 16'h0000, 7'd127}},
      // search of a full queue: last entry, miss over every entry, first entry
      '{rqps_pkg::CMD_FIND, 16'h807C, 1, 1'b0, NO_LITERAL},
      '{rqps_pkg::CMD_FIND, 16'hAAAA, 1, 1'b1,
        '{rqps_pkg::STATUS_NOT_FOUND, 7'd0, 16'h0000, 7'd127}},
      '{rqps_pkg::CMD_FIND, 16'h0000, 1, 1'b0, NO_LITERAL},
      // drain completely, then underflow
      '{rqps_pkg::CMD_DEQUEUE, 16'h0000, 127, 1'b0, NO_LITERAL},
      '{rqps_pkg::CMD_DEQUEUE, 16'h0000, 1, 1'b1,
        '{rqps_pkg::STATUS_EMPTY, 7'd0, 16'h0000, 7'd0}},
      '{rqps_pkg::CMD_FIND, 16'h8000, 1, 1'b1,
        '{rqps_pkg::STATUS_EMPTY, 7'd0, 16'h0000, 7'd0}},
      // pointers have wrapped once around the ring
      '{rqps_pkg::CMD_ENQUEUE, 16'h00FF, 1, 1'b0, NO_LITERAL},
      '{rqps_pkg::CMD_FIND, 16'h00FF, 1, 1'b0, NO_LITERAL}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   rqps_req_if #(.KEY_BITS(KEY_BITS)) req_if ();
   rqps_rsp_if #(.KEY_BITS(KEY_BITS), .INDEX_BITS(INDEX_BITS)) rsp_if ();

   ring_queue_with_position_search_unit #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // literal expectation travels with the request like payload
   logic             row_literal;
   queue_result_type row_literal_result;

   // shadow of the ring; index arithmetic wraps at the 7-bit width
   logic [KEY_BITS-1:0]   slot_shadow [DEPTH];
   logic [INDEX_BITS-1:0] head_shadow;
   logic [INDEX_BITS-1:0] tail_shadow;

   queue_result_type pending_results [$];

   bit idle_on;
   int sent_count;
   int answered_count;
   int error_count;
   int cycle_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // apply one command to the shadow ring and work out its result
   function automatic queue_result_type queue_apply(
      logic [rqps_pkg::CMD_BITS-1:0] command,
      logic [KEY_BITS-1:0]           ticket);
      queue_result_type      r;
      logic [INDEX_BITS-1:0] len;
      logic [INDEX_BITS-1:0] idx;
      bit                    found;
      r = '0;
      found = 1'b0;
      len = tail_shadow - head_shadow;
      case (command)
         rqps_pkg::CMD_ENQUEUE: begin
            if (len == INDEX_BITS'(DEPTH - 1)) begin
               r.status = rqps_pkg::STATUS_FULL;
            end else begin
               slot_shadow[tail_shadow] = ticket;
               tail_shadow = tail_shadow + 1'b1;
            end
         end
         rqps_pkg::CMD_DEQUEUE: begin
            if (len == '0) begin
               r.status = rqps_pkg::STATUS_EMPTY;
            end else begin
               r.removed = slot_shadow[head_shadow];
               head_shadow = head_shadow + 1'b1;
            end
         end
         rqps_pkg::CMD_FIND: begin
            if (len == '0) begin
               r.status = rqps_pkg::STATUS_EMPTY;
            end else begin
               // walk from the head, wrapping, stopping before the tail
               for (int i = 0; i < int'(len); i++) begin
                  idx = head_shadow + INDEX_BITS'(i);
                  if (!found && slot_shadow[idx] == ticket) begin
                     found = 1'b1;
                     r.ahead = INDEX_BITS'(i);
                  end
               end
               if (!found) r.status = rqps_pkg::STATUS_NOT_FOUND;
            end
         end
         default: ;
      endcase
      r.length = tail_shadow - head_shadow;
      return r;
   endfunction

   // finds mostly aim at a stored ticket, else a small pool or anything
   function automatic logic [KEY_BITS-1:0] pick_ticket(
      logic [rqps_pkg::CMD_BITS-1:0] command);
      logic [INDEX_BITS-1:0] len;
      logic [INDEX_BITS-1:0] idx;
      int                    roll;
      len = tail_shadow - head_shadow;
      roll = $urandom_range(99);
      if (command == rqps_pkg::CMD_FIND && len != '0 && roll < 65) begin
         idx = head_shadow + INDEX_BITS'($urandom_range(int'(len) - 1));
         return slot_shadow[idx];
      end
      if (roll < 50) return KEY_BITS'($urandom_range(23));
      return KEY_BITS'($urandom);
   endfunction

   // one transfer on the request channel, with a random gap ahead of it
   task automatic send_ticket_cmd(input logic [rqps_pkg::CMD_BITS-1:0] command,
                                  input logic [KEY_BITS-1:0]           ticket,
                                  input bit                            literal,
                                  input queue_result_type              result);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.command       <= command;
      req_if.ticket_number <= ticket;
      row_literal          <= literal;
      row_literal_result   <= result;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_count++;
   endtask

   // hold the request side until every result is back
   task automatic hold_until_answered();
      req_if.valid <= 1'b0;
      while (answered_count < sent_count) @(posedge clock);
   endtask

   // response side: random back-pressure
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
   end

   // predict on each request transfer, check each response transfer
   always @(posedge clock) begin
      queue_result_type predicted;
      queue_result_type wanted;
      queue_result_type seen;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            predicted = queue_apply(req_if.command, req_if.ticket_number);
            pending_results.push_back(row_literal ? row_literal_result : predicted);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            answered_count++;
            seen = '{rsp_if.status, rsp_if.ahead_count, rsp_if.removed_number,
                     rsp_if.queue_length};
            if (pending_results.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"tb: response with nothing pending: ",
                            "status %0d ahead %0d removed %h len %0d"},
                           seen.status, seen.ahead, seen.removed, seen.length);
            end else begin
               wanted = pending_results.pop_front();
               if (seen !== wanted) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display({"tb: mismatch: status %0d/%0d ahead %0d/%0d ",
                               "removed %h/%h len %0d/%0d (exp/got)"},
                              wanted.status, seen.status, wanted.ahead, seen.ahead,
                              wanted.removed, seen.removed, wanted.length, seen.length);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      logic [rqps_pkg::CMD_BITS-1:0] command;
      logic [KEY_BITS-1:0]           ticket;
      int                            counted;
      int                            mix;
      int                            mix_left;
      int                            roll;
      int                            last_hold;

      req_if.valid         <= 1'b0;
      req_if.command       <= rqps_pkg::CMD_ENQUEUE;
      req_if.ticket_number <= '0;
      row_literal          <= 1'b0;
      row_literal_result   <= NO_LITERAL;
      head_shadow = '0;
      tail_shadow = '0;
      for (int i = 0; i < DEPTH; i++) slot_shadow[i] = '0;
      idle_on = 1'b1;
      sent_count = 0;
      answered_count = 0;
      error_count = 0;
      counted = 0;
      mix = MIX_FILL;
      mix_left = 0;
      last_hold = -1;

      // single synchronous reset at the start
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (ticket_rows[r]) begin
         for (int k = 0; k < ticket_rows[r].reps; k++)
            send_ticket_cmd(ticket_rows[r].command, ticket_rows[r].ticket + KEY_BITS'(k),
                            ticket_rows[r].literal, ticket_rows[r].result);
      end
      hold_until_answered();

      // random part in phases of a biased mix, up to the total item budget
      while (sent_count < TICKET_ITEMS) begin
         if (mix_left == 0) begin
            mix = $urandom_range(MIX_EVEN);
            mix_left = $urandom_range(20, 90);
         end
         // long stretch with no gaps and no back-pressure
         idle_on = !(counted >= 500 && counted < 850);
         // pause the sender now and then until the block has caught up
         if ((counted == 400 || counted == 1100) && last_hold != counted) begin
            last_hold = counted;
            hold_until_answered();
         end
         roll = $urandom_range(99);
         case (mix)
            MIX_FILL:  command = roll < 72 ? rqps_pkg::CMD_ENQUEUE :
                                 roll < 82 ? rqps_pkg::CMD_DEQUEUE :
                                 roll < 97 ? rqps_pkg::CMD_FIND : CMD_UNUSED;
            MIX_DRAIN: command = roll < 15 ? rqps_pkg::CMD_ENQUEUE :
                                 roll < 70 ? rqps_pkg::CMD_DEQUEUE :
                                 roll < 97 ? rqps_pkg::CMD_FIND : CMD_UNUSED;
            default:   command = roll < 38 ? rqps_pkg::CMD_ENQUEUE :
                                 roll < 72 ? rqps_pkg::CMD_DEQUEUE :
                                 roll < 97 ? rqps_pkg::CMD_FIND : CMD_UNUSED;
         endcase
         ticket = pick_ticket(command);
         send_ticket_cmd(command, ticket, 1'b0, NO_LITERAL);
         counted++;
         mix_left--;
      end

      // drain, then let a full search's worth of cycles pass
      idle_on = 1'b1;
      hold_until_answered();
      repeat (DEPTH + 4) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/rqps_pkg.sv
rtl/rqps_req_if.sv
rtl/rqps_rsp_if.sv
rtl/rqps_slot_mem.sv
rtl/ring_queue_with_position_search_unit.sv
tb/tb.sv
